### hdl/kcv_pkg.sv
// ----------------------------------------------------------------------------
// kcv_pkg
// Types, constants and the step program of the two-state Kalman filter.
// ----------------------------------------------------------------------------
package kcv_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned FracW = 16;
  localparam int unsigned AddrW = 5;

  // configuration register indexes
  localparam logic [2:0] REG_TIME_STEP  = 3'd0;
  localparam logic [2:0] REG_REF_VEL    = 3'd1;
  localparam logic [2:0] REG_QPP        = 3'd2;
  localparam logic [2:0] REG_QPV        = 3'd3;
  localparam logic [2:0] REG_QVV        = 3'd4;
  localparam logic [2:0] REG_RP         = 3'd5;
  localparam logic [2:0] REG_RV         = 3'd6;

  // operand codes: 0..15 scratch entries, above that named registers
  localparam logic [4:0] T_XP  = 5'd0;
  localparam logic [4:0] T_M   = 5'd1;
  localparam logic [4:0] T_A   = 5'd2;
  localparam logic [4:0] T_PPP = 5'd3;
  localparam logic [4:0] T_PPV = 5'd4;
  localparam logic [4:0] T_PVV = 5'd5;
  localparam logic [4:0] T_S00 = 5'd6;
  localparam logic [4:0] T_S11 = 5'd7;
  localparam logic [4:0] T_DET = 5'd8;
  localparam logic [4:0] T_K00 = 5'd9;
  localparam logic [4:0] T_K01 = 5'd10;
  localparam logic [4:0] T_K10 = 5'd11;
  localparam logic [4:0] T_K11 = 5'd12;
  localparam logic [4:0] T_Y0  = 5'd13;
  localparam logic [4:0] T_Y1  = 5'd14;
  localparam logic [4:0] T_B   = 5'd15;

  localparam logic [4:0] S_DT   = 5'd16;
  localparam logic [4:0] S_VREF = 5'd17;
  localparam logic [4:0] S_QPP  = 5'd18;
  localparam logic [4:0] S_QPV  = 5'd19;
  localparam logic [4:0] S_QVV  = 5'd20;
  localparam logic [4:0] S_RP   = 5'd21;
  localparam logic [4:0] S_RV   = 5'd22;
  localparam logic [4:0] S_X    = 5'd23;
  localparam logic [4:0] S_V    = 5'd24;
  localparam logic [4:0] S_PPP  = 5'd25;
  localparam logic [4:0] S_PXV  = 5'd26;
  localparam logic [4:0] S_PVV  = 5'd27;
  localparam logic [4:0] S_Z    = 5'd28;
  localparam logic [4:0] S_ZERO = 5'd29;

  localparam logic [4:0] D_X   = 5'd16;
  localparam logic [4:0] D_V   = 5'd17;
  localparam logic [4:0] D_PPP = 5'd18;
  localparam logic [4:0] D_PXV = 5'd19;
  localparam logic [4:0] D_PVV = 5'd20;
  localparam logic [4:0] D_NP  = 5'd21;

  localparam logic [5:0] LastPc = 6'd58;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_EXEC,
    ST_MUL2,
    ST_DIV,
    ST_DIVFIN,
    ST_OUT
  } state_e;

  // cond: result forced to zero without clipping when the determinant is zero
  typedef struct packed {
    op_e        op;
    logic       cond;
    logic       setdet;
    logic [4:0] a;
    logic [4:0] b;
    logic [4:0] d;
  } uop_t;

  typedef struct packed {
    logic signed [DataW-1:0] position_sample;
  } in_data_t;

  function automatic uop_t mk(op_e op, logic [4:0] a, logic [4:0] b, logic [4:0] d,
                              logic c, logic s);
    uop_t u;
    u.op = op; u.a = a; u.b = b; u.d = d; u.cond = c; u.setdet = s;
    return u;
  endfunction

  function automatic uop_t uop_rom(logic [5:0] pc);
    uop_t u;
    case (pc)
      // predict
      6'd0:  u = mk(OP_MUL, S_DT,  S_V,   T_A,   1'b0, 1'b0);
      6'd1:  u = mk(OP_ADD, S_X,   T_A,   T_XP,  1'b0, 1'b0);
      6'd2:  u = mk(OP_MUL, S_DT,  S_PVV, T_A,   1'b0, 1'b0);
      6'd3:  u = mk(OP_ADD, S_PXV, T_A,   T_M,   1'b0, 1'b0);
      6'd4:  u = mk(OP_MUL, S_DT,  S_PXV, T_A,   1'b0, 1'b0);
      6'd5:  u = mk(OP_ADD, S_PPP, T_A,   T_A,   1'b0, 1'b0);
      6'd6:  u = mk(OP_MUL, S_DT,  T_M,   T_B,   1'b0, 1'b0);
      6'd7:  u = mk(OP_ADD, T_A,   T_B,   T_A,   1'b0, 1'b0);
      6'd8:  u = mk(OP_ADD, T_A,   S_QPP, T_PPP, 1'b0, 1'b0);
      6'd9:  u = mk(OP_ADD, T_M,   S_QPV, T_PPV, 1'b0, 1'b0);
      6'd10: u = mk(OP_ADD, S_PVV, S_QVV, T_PVV, 1'b0, 1'b0);
      // innovation covariance and determinant
      6'd11: u = mk(OP_ADD, T_PPP, S_RP,  T_S00, 1'b0, 1'b0);
      6'd12: u = mk(OP_ADD, T_PVV, S_RV,  T_S11, 1'b0, 1'b0);
      6'd13: u = mk(OP_MUL, T_S00, T_S11, T_A,   1'b0, 1'b0);
      6'd14: u = mk(OP_MUL, T_PPV, T_PPV, T_B,   1'b0, 1'b0);
      6'd15: u = mk(OP_SUB, T_A,   T_B,   T_DET, 1'b0, 1'b1);
      // gains
      6'd16: u = mk(OP_MUL, T_PPP, T_S11, T_A,   1'b1, 1'b0);
      6'd17: u = mk(OP_MUL, T_PPV, T_PPV, T_B,   1'b1, 1'b0);
      6'd18: u = mk(OP_SUB, T_A,   T_B,   T_A,   1'b1, 1'b0);
      6'd19: u = mk(OP_DIV, T_A,   T_DET, T_K00, 1'b1, 1'b0);
      6'd20: u = mk(OP_MUL, T_PPV, T_S00, T_A,   1'b1, 1'b0);
      6'd21: u = mk(OP_MUL, T_PPP, T_PPV, T_B,   1'b1, 1'b0);
      6'd22: u = mk(OP_SUB, T_A,   T_B,   T_A,   1'b1, 1'b0);
      6'd23: u = mk(OP_DIV, T_A,   T_DET, T_K01, 1'b1, 1'b0);
      6'd24: u = mk(OP_MUL, T_PPV, T_S11, T_A,   1'b1, 1'b0);
      6'd25: u = mk(OP_MUL, T_PVV, T_PPV, T_B,   1'b1, 1'b0);
      6'd26: u = mk(OP_SUB, T_A,   T_B,   T_A,   1'b1, 1'b0);
      6'd27: u = mk(OP_DIV, T_A,   T_DET, T_K10, 1'b1, 1'b0);
      6'd28: u = mk(OP_MUL, T_PVV, T_S00, T_A,   1'b1, 1'b0);
      6'd29: u = mk(OP_MUL, T_PPV, T_PPV, T_B,   1'b1, 1'b0);
      6'd30: u = mk(OP_SUB, T_A,   T_B,   T_A,   1'b1, 1'b0);
      6'd31: u = mk(OP_DIV, T_A,   T_DET, T_K11, 1'b1, 1'b0);
      // state update
      6'd32: u = mk(OP_SUB, S_Z,   T_XP,  T_Y0,  1'b0, 1'b0);
      6'd33: u = mk(OP_SUB, S_VREF, S_V,  T_Y1,  1'b0, 1'b0);
      6'd34: u = mk(OP_MUL, T_K00, T_Y0,  T_A,   1'b0, 1'b0);
      6'd35: u = mk(OP_MUL, T_K01, T_Y1,  T_B,   1'b0, 1'b0);
      6'd36: u = mk(OP_ADD, T_A,   T_B,   T_A,   1'b0, 1'b0);
      6'd37: u = mk(OP_ADD, T_XP,  T_A,   T_M,   1'b0, 1'b0);
      6'd38: u = mk(OP_MUL, T_K10, T_Y0,  T_A,   1'b0, 1'b0);
      6'd39: u = mk(OP_MUL, T_K11, T_Y1,  T_B,   1'b0, 1'b0);
      6'd40: u = mk(OP_ADD, T_A,   T_B,   T_A,   1'b0, 1'b0);
      6'd41: u = mk(OP_ADD, S_V,   T_A,   T_S00, 1'b0, 1'b0);
      // covariance update
      6'd42: u = mk(OP_MUL, T_K00, T_PPP, T_A,   1'b0, 1'b0);
      6'd43: u = mk(OP_MUL, T_K01, T_PPV, T_B,   1'b0, 1'b0);
      6'd44: u = mk(OP_ADD, T_A,   T_B,   T_A,   1'b0, 1'b0);
      6'd45: u = mk(OP_SUB, T_PPP, T_A,   D_PPP, 1'b0, 1'b0);
      6'd46: u = mk(OP_MUL, T_K00, T_PPV, T_A,   1'b0, 1'b0);
      6'd47: u = mk(OP_MUL, T_K01, T_PVV, T_B,   1'b0, 1'b0);
      6'd48: u = mk(OP_ADD, T_A,   T_B,   T_A,   1'b0, 1'b0);
      6'd49: u = mk(OP_SUB, T_PPV, T_A,   D_PXV, 1'b0, 1'b0);
      6'd50: u = mk(OP_MUL, T_K10, T_PPV, T_A,   1'b0, 1'b0);
      6'd51: u = mk(OP_MUL, T_K11, T_PVV, T_B,   1'b0, 1'b0);
      6'd52: u = mk(OP_ADD, T_A,   T_B,   T_A,   1'b0, 1'b0);
      6'd53: u = mk(OP_SUB, T_PVV, T_A,   D_PVV, 1'b0, 1'b0);
      // forecast and commit
      6'd54: u = mk(OP_MUL, S_VREF, S_DT, T_A,   1'b0, 1'b0);
      6'd55: u = mk(OP_ADD, T_M,   T_A,   T_B,   1'b0, 1'b0);
      6'd56: u = mk(OP_ADD, T_M,   S_ZERO, D_X,  1'b0, 1'b0);
      6'd57: u = mk(OP_ADD, T_S00, S_ZERO, D_V,  1'b0, 1'b0);
      6'd58: u = mk(OP_ADD, T_B,   S_ZERO, D_NP, 1'b0, 1'b0);
      default: u = mk(OP_ADD, S_ZERO, S_ZERO, T_A, 1'b0, 1'b0);
    endcase
    return u;
  endfunction

  // saturate a wide signed value to the data range; bit DataW is the clip flag
  function automatic logic [DataW:0] clip64(logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sd2147483647;
    lo = -64'sd2147483648;
    if (v > hi) begin
      return {1'b1, hi[DataW-1:0]};
    end else if (v < lo) begin
      return {1'b1, lo[DataW-1:0]};
    end
    return {1'b0, v[DataW-1:0]};
  endfunction

endpackage

### hdl/kcv_in_if.sv
// ----------------------------------------------------------------------------
// kcv_in_if
// Measurement channel: valid/ready with one position sample.
// ----------------------------------------------------------------------------
interface kcv_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] position_sample;

  modport source (output valid, output position_sample, input ready);
  modport sink   (input valid, input position_sample, output ready);
endinterface

### hdl/kcv_out_if.sv
// ----------------------------------------------------------------------------
// kcv_out_if
// Result channel: valid/ready with the updated estimate and forecast.
// ----------------------------------------------------------------------------
interface kcv_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] est_position;
  logic signed [31:0] est_velocity;
  logic signed [31:0] next_position;
  logic               saturated;

  modport source (output valid, output est_position, output est_velocity,
                  output next_position, output saturated, input ready);
  modport sink   (input valid, input est_position, input est_velocity,
                  input next_position, input saturated, output ready);
endinterface

### hdl/kalman_cv_two_state_filter.sv
// ----------------------------------------------------------------------------
// kalman_cv_two_state_filter
// Constant-velocity two-state Kalman filter, Q16.16 with saturation.
// ----------------------------------------------------------------------------
// One position sample is taken when the block is idle; the filter step then
// runs as a 59-instruction program on a single shared unit (add/subtract with
// clip, 32x32 multiply with round, restoring divider) and the result is held
// until the output transfer completes. Each step reads its operands and
// executes; a multiply rounds in a second state, a divide takes one quotient
// bit per cycle over 48 bits. There are 30 add/sub, 25 multiply and 4 divide
// steps; with a zero determinant the gain steps write zero without computing.
// The user must write configuration over APB only while no step is in flight;
// the block itself does not enforce this.
module kalman_cv_two_state_filter (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  kcv_in_if.sink                    in_if,
  kcv_out_if.source                 out_if,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [kcv_pkg::AddrW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import kcv_pkg::*;

  // configuration
  logic [30:0]        dt_q, qpp_q, qvv_q, rp_q, rv_q;
  logic signed [31:0] vref_q, qpv_q;
  // filter state and result
  logic signed [31:0] x_q, v_q, ppp_q, pxv_q, pvv_q, np_q, z_q;
  logic               sat_q, det_zero_q;

  state_e state_q, state_d;
  logic [5:0] pc_q;
  uop_t       uop;

  logic signed [31:0] tmp_mem [16];
  logic signed [31:0] ta_q, tb_q, fa_q, fb_q, fa_d, fb_d;
  logic signed [31:0] opa, opb;
  logic signed [63:0] prod_q;

  // divider
  logic [47:0] dn_q, quo_q;
  logic [31:0] dd_q;
  logic [32:0] rem_q, rem_sh, rem_d;
  logic        dneg_q, ge;
  logic [5:0]  cnt_q;
  logic [31:0] abs_a, abs_b;

  logic               wb_en;
  logic signed [31:0] wb_val;
  logic               wb_clip;
  logic [DataW:0]     cl;
  logic signed [63:0] rnd;
  logic signed [63:0] qsig;
  logic               cfg_wr;

  assign uop = uop_rom(pc_q);

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_comb begin
    case (paddr[AddrW-1:2])
      REG_TIME_STEP: prdata = {1'b0, dt_q};
      REG_REF_VEL:   prdata = vref_q;
      REG_QPP:       prdata = {1'b0, qpp_q};
      REG_QPV:       prdata = qpv_q;
      REG_QVV:       prdata = {1'b0, qvv_q};
      REG_RP:        prdata = {1'b0, rp_q};
      REG_RV:        prdata = {1'b0, rv_q};
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dt_q   <= 31'd65536;
      vref_q <= 32'sd655360;
      qpp_q  <= 31'd655;
      qpv_q  <= 32'sd1311;
      qvv_q  <= 31'd6554;
      rp_q   <= 31'd32768;
      rv_q   <= 31'd32768;
    end else if (cfg_wr) begin
      case (paddr[AddrW-1:2])
        REG_TIME_STEP: dt_q   <= pwdata[30:0];
        REG_REF_VEL:   vref_q <= pwdata;
        REG_QPP:       qpp_q  <= pwdata[30:0];
        REG_QPV:       qpv_q  <= pwdata;
        REG_QVV:       qvv_q  <= pwdata[30:0];
        REG_RP:        rp_q   <= pwdata[30:0];
        REG_RV:        rv_q   <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  // named-register operand select
  function automatic logic signed [31:0] fsel(
    logic [4:0] c, logic [30:0] dt, logic signed [31:0] vref, logic [30:0] qpp,
    logic signed [31:0] qpv, logic [30:0] qvv, logic [30:0] rp, logic [30:0] rv,
    logic signed [31:0] x, logic signed [31:0] v, logic signed [31:0] ppp,
    logic signed [31:0] pxv, logic signed [31:0] pvv, logic signed [31:0] z);
    logic signed [31:0] r;
    case (c)
      S_DT:    r = {1'b0, dt};
      S_VREF:  r = vref;
      S_QPP:   r = {1'b0, qpp};
      S_QPV:   r = qpv;
      S_QVV:   r = {1'b0, qvv};
      S_RP:    r = {1'b0, rp};
      S_RV:    r = {1'b0, rv};
      S_X:     r = x;
      S_V:     r = v;
      S_PPP:   r = ppp;
      S_PXV:   r = pxv;
      S_PVV:   r = pvv;
      S_Z:     r = z;
      default: r = '0;
    endcase
    return r;
  endfunction

  assign fa_d = fsel(uop.a, dt_q, vref_q, qpp_q, qpv_q, qvv_q, rp_q, rv_q,
                     x_q, v_q, ppp_q, pxv_q, pvv_q, z_q);
  assign fb_d = fsel(uop.b, dt_q, vref_q, qpp_q, qpv_q, qvv_q, rp_q, rv_q,
                     x_q, v_q, ppp_q, pxv_q, pvv_q, z_q);

  assign opa = uop.a[4] ? fa_q : ta_q;
  assign opb = uop.b[4] ? fb_q : tb_q;

  assign abs_a = opa[31] ? 32'(-opa) : 32'(opa);
  assign abs_b = opb[31] ? 32'(-opb) : 32'(opb);

  assign rem_sh = {rem_q[31:0], dn_q[47]};
  assign ge     = rem_sh >= {1'b0, dd_q};
  assign rem_d  = ge ? rem_sh - {1'b0, dd_q} : rem_sh;

  assign rnd  = (prod_q + 64'sd32768) >>> FracW;
  assign qsig = dneg_q ? -$signed({16'd0, quo_q}) : $signed({16'd0, quo_q});

  // write-back value and next state
  always_comb begin
    state_d = state_q;
    wb_en   = 1'b0;
    wb_val  = '0;
    wb_clip = 1'b0;
    cl      = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_if.valid) begin
          state_d = ST_READ;
        end
      end
      ST_READ: state_d = ST_EXEC;
      ST_EXEC: begin
        if (uop.cond && det_zero_q) begin
          wb_en = 1'b1;
        end else begin
          case (uop.op)
            OP_ADD: begin
              cl = clip64(64'(opa) + 64'(opb));
              wb_en = 1'b1;
            end
            OP_SUB: begin
              cl = clip64(64'(opa) - 64'(opb));
              wb_en = 1'b1;
            end
            OP_MUL:  state_d = ST_MUL2;
            default: state_d = ST_DIV;
          endcase
          wb_val  = $signed(cl[DataW-1:0]);
          wb_clip = cl[DataW];
        end
      end
      ST_MUL2: begin
        cl      = clip64(rnd);
        wb_en   = 1'b1;
        wb_val  = $signed(cl[DataW-1:0]);
        wb_clip = cl[DataW];
      end
      ST_DIV: begin
        if (cnt_q == 6'd47) begin
          state_d = ST_DIVFIN;
        end
      end
      ST_DIVFIN: begin
        cl      = clip64(qsig);
        wb_en   = 1'b1;
        wb_val  = $signed(cl[DataW-1:0]);
        wb_clip = cl[DataW];
      end
      ST_OUT: begin
        if (out_if.ready) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    if (wb_en) begin
      state_d = (pc_q == LastPc) ? ST_OUT : ST_READ;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      pc_q       <= '0;
      sat_q      <= 1'b0;
      det_zero_q <= 1'b0;
      x_q        <= '0;
      v_q        <= '0;
      ppp_q      <= 32'sd65536;
      pxv_q      <= '0;
      pvv_q      <= 32'sd65536;
    end else begin
      state_q <= state_d;
      if (state_q == ST_IDLE && in_if.valid) begin
        pc_q       <= '0;
        sat_q      <= 1'b0;
        det_zero_q <= 1'b0;
      end
      if (wb_en) begin
        pc_q  <= pc_q + 6'd1;
        sat_q <= sat_q | wb_clip;
        if (uop.setdet) begin
          det_zero_q <= (wb_val == '0);
        end
        case (uop.d)
          D_X:   x_q   <= wb_val;
          D_V:   v_q   <= wb_val;
          D_PPP: ppp_q <= wb_val;
          D_PXV: pxv_q <= wb_val;
          D_PVV: pvv_q <= wb_val;
          default: ;
        endcase
      end
    end
  end

  // payload and datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_if.valid) begin
      z_q <= in_if.position_sample;
    end
    if (state_q == ST_READ) begin
      ta_q <= tmp_mem[uop.a[3:0]];
      tb_q <= tmp_mem[uop.b[3:0]];
      fa_q <= fa_d;
      fb_q <= fb_d;
    end
    if (wb_en) begin
      if (!uop.d[4]) begin
        tmp_mem[uop.d[3:0]] <= wb_val;
      end
      if (uop.d == D_NP) begin
        np_q <= wb_val;
      end
    end
    if (state_q == ST_EXEC) begin
      prod_q <= opa * opb;
      dn_q   <= {abs_a, 16'd0};
      dd_q   <= abs_b;
      dneg_q <= opa[31] ^ opb[31];
      rem_q  <= '0;
      quo_q  <= '0;
      cnt_q  <= '0;
    end
    if (state_q == ST_DIV) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[46:0], ge};
      dn_q  <= {dn_q[46:0], 1'b0};
      cnt_q <= cnt_q + 6'd1;
    end
  end

  assign in_if.ready          = (state_q == ST_IDLE);
  assign out_if.valid         = (state_q == ST_OUT);
  assign out_if.est_position  = x_q;
  assign out_if.est_velocity  = v_q;
  assign out_if.next_position = np_q;
  assign out_if.saturated     = sat_q;

endmodule

### hdl/kcv_checker.sv
// ----------------------------------------------------------------------------
// kcv_checker
// Port-level checks of the filter's transfer sequencing.
// ----------------------------------------------------------------------------
module kcv_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_pos
);

  // a result waits until taken, unchanged
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_pos))
    else $error("result dropped or changed while stalled");

  // busy right after a sample is taken
  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready)
    else $error("ready again right after input transfer");

  // never a result in the cycle after a sample is taken
  a_no_instant_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !out_valid)
    else $error("result shown without computation");

  // one item in flight: no new sample while a result waits
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> !in_ready)
    else $error("input taken while result pending");

endmodule

bind kalman_cv_two_state_filter kcv_checker u_kcv_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_if.valid),
  .in_ready  (in_if.ready),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .out_pos   (out_if.est_position)
);

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the two-state constant-velocity Kalman filter.
// It streams position samples under random flow control. An in-bench Q16.16
// model of the filter step predicts every estimate and forecast. Registers
// are reprogrammed over APB between phases, extremes included.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import kcv_pkg::*;

  typedef struct {
    logic signed [31:0] est_position;
    logic signed [31:0] est_velocity;
    logic signed [31:0] next_position;
    logic               saturated;
  } estimate_t;

  localparam longint QHI = 64'sd2147483647;
  localparam longint QLO = -64'sd2147483648;

  logic        clk_i;
  logic        rst_ni;
  logic        psel, penable, pwrite;
  logic [AddrW-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  kcv_in_if  meas_ch ();
  kcv_out_if est_ch ();

  kalman_cv_two_state_filter i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (meas_ch.sink),
    .out_if (est_ch.source),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // register mirror and filter state of the bench model
  logic [31:0] reg_mirror [7];
  longint      x_est, v_est, p_pp, p_pv, p_vv;
  logic        clipped;

  estimate_t   pending_est [$];
  int          n_fail;
  int          n_sent;
  int          n_checked;
  int          n_zero_det;
  int          send_idle_pct;
  int          recv_idle_pct;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #25ms;
    $display("== FAIL ==");
    $finish;
  end

  function automatic longint sat(longint v);
    if (v > QHI) begin
      clipped = 1'b1;
      return QHI;
    end
    if (v < QLO) begin
      clipped = 1'b1;
      return QLO;
    end
    return v;
  endfunction

  function automatic longint qadd(longint a, longint b);
    return sat(a + b);
  endfunction

  function automatic longint qsub(longint a, longint b);
    return sat(a - b);
  endfunction

  // round half up, floor shift
  function automatic longint qmul(longint a, longint b);
    return sat((a * b + 64'sd32768) >>> FracW);
  endfunction

  function automatic longint qdiv(longint num, longint den);
    return sat((num * 64'sd65536) / den);
  endfunction

  function automatic void filter_reset();
    reg_mirror[REG_TIME_STEP] = 32'd65536;
    reg_mirror[REG_REF_VEL]   = 32'd655360;
    reg_mirror[REG_QPP]       = 32'd655;
    reg_mirror[REG_QPV]       = 32'd1311;
    reg_mirror[REG_QVV]       = 32'd6554;
    reg_mirror[REG_RP]        = 32'd32768;
    reg_mirror[REG_RV]        = 32'd32768;
    x_est = 0;
    v_est = 0;
    p_pp  = 65536;
    p_pv  = 0;
    p_vv  = 65536;
  endfunction

  function automatic estimate_t filter_step(logic signed [31:0] z);
    longint dt, vref, xp, vp, m, ppp, ppv, pvv, s00, s11, det;
    longint k00, k01, k10, k11, y0, y1, nx, nv;
    estimate_t e;
    clipped = 1'b0;
    k00 = 0; k01 = 0; k10 = 0; k11 = 0;
    dt   = longint'(reg_mirror[REG_TIME_STEP][30:0]);
    vref = longint'($signed(reg_mirror[REG_REF_VEL]));
    xp = qadd(x_est, qmul(dt, v_est));
    vp = v_est;
    m   = qadd(p_pv, qmul(dt, p_vv));
    ppp = qadd(qadd(qadd(p_pp, qmul(dt, p_pv)), qmul(dt, m)),
               longint'(reg_mirror[REG_QPP][30:0]));
    ppv = qadd(m, longint'($signed(reg_mirror[REG_QPV])));
    pvv = qadd(p_vv, longint'(reg_mirror[REG_QVV][30:0]));
    s00 = qadd(ppp, longint'(reg_mirror[REG_RP][30:0]));
    s11 = qadd(pvv, longint'(reg_mirror[REG_RV][30:0]));
    det = qsub(qmul(s00, s11), qmul(ppv, ppv));
    if (det != 0) begin
      k00 = qdiv(qsub(qmul(ppp, s11), qmul(ppv, ppv)), det);
      k01 = qdiv(qsub(qmul(ppv, s00), qmul(ppp, ppv)), det);
      k10 = qdiv(qsub(qmul(ppv, s11), qmul(pvv, ppv)), det);
      k11 = qdiv(qsub(qmul(pvv, s00), qmul(ppv, ppv)), det);
    end else begin
      n_zero_det++;
    end
    y0 = qsub(longint'(z), xp);
    y1 = qsub(vref, vp);
    nx = qadd(xp, qadd(qmul(k00, y0), qmul(k01, y1)));
    nv = qadd(vp, qadd(qmul(k10, y0), qmul(k11, y1)));
    p_pp  = qsub(ppp, qadd(qmul(k00, ppp), qmul(k01, ppv)));
    p_pv  = qsub(ppv, qadd(qmul(k00, ppv), qmul(k01, pvv)));
    p_vv  = qsub(pvv, qadd(qmul(k10, ppv), qmul(k11, pvv)));
    x_est = nx;
    v_est = nv;
    e.est_position  = nx[31:0];
    e.est_velocity  = nv[31:0];
    e.next_position = 32'(qadd(nx, qmul(vref, dt)));
    e.saturated     = clipped;
    return e;
  endfunction

  // one APB write: setup cycle, then access cycle
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrW'({idx, 2'b00});
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_TIME_STEP || idx == REG_QPP || idx == REG_QVV ||
        idx == REG_RP || idx == REG_RV) begin
      reg_mirror[idx] = {1'b0, val[30:0]};
    end else begin
      reg_mirror[idx] = val;
    end
  endtask

  task automatic wait_drained();
    meas_ch.valid <= 1'b0;
    while (pending_est.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // valid stays up after a transfer; the idle loop or the drain drops it
  task automatic send_sample(logic signed [31:0] z);
    while ($urandom_range(99) < send_idle_pct) begin
      meas_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    meas_ch.valid           <= 1'b1;
    meas_ch.position_sample <= z;
    @(posedge clk_i);
    while (!meas_ch.ready) @(posedge clk_i);
    pending_est.insert(pending_est.size(), filter_step(z));
    n_sent++;
  endtask

  always @(posedge clk_i) begin
    est_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    estimate_t want;
    if (rst_ni && est_ch.valid && est_ch.ready) begin
      if (pending_est.size() == 0) begin
        $error("result transfer with nothing expected");
        n_fail++;
      end else begin
        want = pending_est.pop_front();
        n_checked++;
        if (est_ch.est_position !== want.est_position) begin
          $error("est_position exp %0d got %0d", want.est_position, est_ch.est_position);
          n_fail++;
        end
        if (est_ch.est_velocity !== want.est_velocity) begin
          $error("est_velocity exp %0d got %0d", want.est_velocity, est_ch.est_velocity);
          n_fail++;
        end
        if (est_ch.next_position !== want.next_position) begin
          $error("next_position exp %0d got %0d", want.next_position,
                 est_ch.next_position);
          n_fail++;
        end
        if (est_ch.saturated !== want.saturated) begin
          $error("saturated exp %0b got %0b", want.saturated, est_ch.saturated);
          n_fail++;
        end
      end
    end
  end

  task automatic test_directed();
    send_idle_pct = 16;
    recv_idle_pct = 45;
    send_sample(32'sd0);
    send_sample(32'sd655360);
    send_sample(32'sh7fffffff);
    send_sample(32'sh80000000);
    send_sample(-32'sd65536);
    send_sample(32'sd1);
    wait_drained();
    // gains go to zero once the covariance collapses
    write_reg(REG_TIME_STEP, 32'd0);
    write_reg(REG_QPP, 32'd0);
    write_reg(REG_QPV, 32'd0);
    write_reg(REG_QVV, 32'd0);
    write_reg(REG_RP, 32'd0);
    write_reg(REG_RV, 32'd0);
    repeat (4) send_sample($signed($urandom));
    wait_drained();
    // extremes of every register, heavy clipping
    write_reg(REG_TIME_STEP, 32'hffffffff);
    write_reg(REG_REF_VEL, 32'h80000000);
    write_reg(REG_QPP, 32'h7fffffff);
    write_reg(REG_QPV, 32'h7fffffff);
    write_reg(REG_QVV, 32'h7fffffff);
    write_reg(REG_RP, 32'h7fffffff);
    write_reg(REG_RV, 32'h7fffffff);
    send_sample(32'sh7fffffff);
    send_sample(32'sh80000000);
    send_sample(32'sd0);
    wait_drained();
    write_reg(REG_REF_VEL, 32'h7fffffff);
    write_reg(REG_QPV, 32'h80000000);
    send_sample(32'sh80000000);
    send_sample(32'sh7fffffff);
    wait_drained();
  endtask

  task automatic load_random_settings();
    if ($urandom_range(3) == 0) begin
      write_reg(REG_TIME_STEP, $urandom);
      write_reg(REG_REF_VEL, $urandom);
      write_reg(REG_QPP, $urandom);
      write_reg(REG_QPV, $urandom);
      write_reg(REG_QVV, $urandom);
      write_reg(REG_RP, $urandom);
      write_reg(REG_RV, $urandom);
    end else begin
      write_reg(REG_TIME_STEP, $urandom_range(131072, 1024));
      write_reg(REG_REF_VEL, $signed($urandom_range(2000000)) - 32'sd1000000);
      write_reg(REG_QPP, $urandom_range(20000));
      write_reg(REG_QPV, $signed($urandom_range(20000)) - 32'sd10000);
      write_reg(REG_QVV, $urandom_range(20000));
      write_reg(REG_RP, $urandom_range(200000));
      write_reg(REG_RV, $urandom_range(200000));
    end
  endtask

  // track a moving target with noise; an occasional wild sample
  task automatic run_tracking(int n_items);
    longint pos;
    longint vel;
    pos = x_est;
    vel = $signed($urandom_range(400000)) - 200000;
    for (int i = 0; i < n_items; i++) begin
      pos = pos + vel + ($signed($urandom_range(20000)) - 10000);
      if (pos > QHI || pos < QLO) pos = 0;
      if ($urandom_range(9) == 0) begin
        send_sample($signed($urandom));
      end else begin
        send_sample(pos[31:0]);
      end
    end
  endtask

  task automatic test_random_traffic(int s_pct, int r_pct);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (int phase = 0; phase < 4; phase++) begin
      wait_drained();
      load_random_settings();
      run_tracking(102);
    end
    wait_drained();
  endtask

  initial begin
    rst_ni  = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    meas_ch.valid           = 1'b0;
    meas_ch.position_sample = '0;
    n_fail = 0;
    n_sent = 0;
    n_checked = 0;
    n_zero_det = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    filter_reset();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_traffic(16, 45);
    test_random_traffic(45, 16);
    test_random_traffic(0, 0);

    wait_drained();
    repeat (500) @(posedge clk_i);
    $display("Covered %0d samples, %0d results checked, %0d zero-determinant steps,",
             n_sent, n_checked, n_zero_det);
    $display("over directed extremes and random register settings and flow control.");
    if (n_fail == 0 && pending_est.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
